[hw/rtl/atwm_pkg.sv]
// Shared types, constants and opcodes for the alarm table weekday matcher.
package atwm_pkg;

  localparam int MaxAlarms = 8;
  localparam int SlotW     = (MaxAlarms > 1) ? $clog2(MaxAlarms) : 1;
  localparam int CntW      = $clog2(MaxAlarms + 1);
  localparam int NextCell  = (MaxAlarms > 1) ? 1 : 0;

  localparam int WordW   = 32;
  localparam int ItemW   = 23;
  localparam int IdW     = 4;
  localparam int HourLsb = 4;
  localparam int MinLsb  = 9;
  localparam int EnBit   = 15;
  localparam int RepLsb  = 16;

  localparam logic [WordW-1:0] TimeMask = 32'h0000_7FF0;
  localparam logic [WordW-1:0] RepMask  = 32'h007F_0000;
  localparam logic [WordW-1:0] EnMask   = 32'h0000_8000;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SET_TIM = 3'd1,
    OP_SET_REP = 3'd2,
    OP_SET_EN  = 3'd3,
    OP_DEL_ONE = 3'd4,
    OP_DEL_ALL = 3'd5,
    OP_READ    = 3'd6,
    OP_TICK    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // One accepted command with its operands.
  typedef struct packed {
    op_t              op;
    logic [ItemW-1:0] word;
    logic [7:0]       target;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [2:0]       weekday;
  } job_t;

  // Per-step context handed to the head cell.
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  count;
    logic             found;
  } step_t;

  // What the head cell reports for the slot it is working on.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             hit;
  } head_res_t;

endpackage

[hw/rtl/atwm_cell.sv]
// One storage cell of the rotating alarm word chain.
module atwm_cell
  import atwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [WordW-1:0] din,
  output logic [WordW-1:0] q
);

  logic [WordW-1:0] word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (shift) begin
      word <= din;
    end
  end

  assign q = word;

endmodule

[hw/rtl/atwm_head.sv]
// Head of the chain: applies the command to the word passing slot position zero.
module atwm_head
  import atwm_pkg::*;
(
  input  job_t             job,
  input  step_t            step,
  input  logic [WordW-1:0] empty_word,
  input  logic [WordW-1:0] cur,
  input  logic [WordW-1:0] nxt,
  output head_res_t        res
);

  logic             in_range;
  logic             id_hit;
  logic             del_hit;
  logic             last_held;
  logic             time_hit;
  logic [6:0]       rep;
  logic [7:0]       rep_ext;
  logic             day_bit;
  logic             fire;
  logic [WordW-1:0] mask;
  logic [WordW-1:0] item_ext;

  always_comb begin
    in_range  = CntW'(step.slot) < step.count;
    last_held = CntW'(step.slot) == (step.count - CntW'(1));
    item_ext  = WordW'(job.word);
    id_hit    = !step.found && in_range && (cur[IdW-1:0] == job.word[IdW-1:0]);
    del_hit   = !step.found && in_range && (job.target[7:IdW] == '0)
                && (cur[IdW-1:0] == job.target[IdW-1:0]);
    time_hit  = (cur[MinLsb-1:HourLsb] == job.hour)
                && (cur[EnBit-1:MinLsb] == job.minute);
    rep       = cur[RepLsb+6:RepLsb];
    rep_ext   = {1'b0, rep} >> job.weekday;
    day_bit   = rep_ext[0];
    fire      = !step.found && in_range && cur[EnBit] && time_hit
                && ((rep == '0) || day_bit);

    unique case (job.op)
      OP_SET_TIM: mask = TimeMask;
      OP_SET_REP: mask = RepMask;
      default:    mask = EnMask;
    endcase

    res.word = cur;
    res.hit  = 1'b0;
    unique case (job.op)
      OP_ADD: begin
        if ((CntW'(step.slot) == step.count) && (step.count < CntW'(MaxAlarms))) begin
          res.word = {empty_word[WordW-1:ItemW], job.word};
        end
      end
      OP_SET_TIM, OP_SET_REP, OP_SET_EN: begin
        res.hit = id_hit;
        if (id_hit) begin
          res.word = (cur & ~mask) | (item_ext & mask);
        end
      end
      OP_DEL_ONE: begin
        res.hit = del_hit;
        if ((step.found || del_hit) && in_range) begin
          if (last_held) begin
            res.word = empty_word;
          end else begin
            res.word = {nxt[WordW-1:IdW], cur[IdW-1:0]};
          end
        end
      end
      OP_DEL_ALL: begin
        if (in_range) begin
          res.word = empty_word;
        end
      end
      OP_READ: begin
        res.hit = in_range && (job.target == 8'(step.slot));
      end
      OP_TICK: begin
        res.hit = fire;
        if (fire && (rep == '0)) begin
          res.word = cur & ~EnMask;
        end
      end
      default: begin
        res.word = cur;
      end
    endcase
  end

endmodule

[hw/rtl/alarm_table_weekday_matcher.sv]
// Top level of the alarm table weekday matcher: command control, cell chain, result register.
// A new command is not taken until the previous one has finished its chain turn and loaded its result.
// A new command may be accepted while the previous result still waits on the output.
// Reset (rst, synchronous, active high) clears every slot to zero, the count, the last
// fired slot and empty_word; no clearing pass is needed afterwards.
module alarm_table_weekday_matcher
  import atwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Command beats. tuser: opcode[2:0].
  // tdata: alarm_word[22:0], target[30:23], now_hour[35:31], now_minute[41:36],
  //        weekday[44:42], zero fill[47:45].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  // Result beats. tdata: read_word[31:0], status[33:32], fired[34], fired_slot[38:35],
  //                      entry_total[43:39], zero fill[47:44].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // Write port of the empty_word register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FIN
  } state_t;

  state_t           state;
  job_t             job;
  logic [SlotW-1:0] slot;
  logic [CntW-1:0]  count;
  logic             found;
  logic [SlotW-1:0] fired_slot;
  logic [WordW-1:0] read_cap;
  logic [WordW-1:0] empty_word;
  logic             out_valid;
  logic [WordW-1:0] out_read_word;
  status_t          out_status;
  logic             out_fired;
  logic [3:0]       out_fired_slot;
  logic [4:0]       out_total;

  logic             accept;
  logic             shift;
  logic             load_out;
  logic [WordW-1:0] cell_q [MaxAlarms];
  step_t            step;
  head_res_t        head;
  logic [CntW-1:0]  count_next;
  status_t          status_next;
  logic [WordW-1:0] read_next;

  assign s_axis_tready = (state == IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift         = (state == RUN);
  assign load_out      = (state == FIN) && (!out_valid || m_axis_tready);
  assign cfg_ready     = 1'b1;

  // The chain turns once per command: each cell takes its upper neighbor's word,
  // and the top cell takes the word that the head unit has just processed. After
  // MaxAlarms shifts every word is back in its own slot.
  for (genvar i = 0; i < MaxAlarms; i++) begin : g_cell
    logic [WordW-1:0] din;
    if (i == MaxAlarms - 1) begin : g_top
      assign din = head.word;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    atwm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (din),
      .q     (cell_q[i])
    );
  end

  assign step.slot  = slot;
  assign step.count = count;
  assign step.found = found;

  // The head sees the word of the current slot and, for a delete, the word of
  // the slot above it, which is what moves down.
  atwm_head u_head (
    .job        (job),
    .step       (step),
    .empty_word (empty_word),
    .cur        (cell_q[0]),
    .nxt        (cell_q[NextCell]),
    .res        (head)
  );

  // Result and count once the turn is complete.
  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    read_next   = '0;
    unique case (job.op)
      OP_ADD: begin
        if (count >= CntW'(MaxAlarms)) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CntW'(1);
        end
      end
      OP_SET_TIM, OP_SET_REP, OP_SET_EN: begin
        if (!found) begin
          status_next = ST_NOTFOUND;
        end
      end
      OP_DEL_ONE: begin
        if (found) begin
          count_next = count - CntW'(1);
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      OP_DEL_ALL: begin
        count_next = '0;
      end
      OP_READ: begin
        if (found) begin
          read_next = read_cap;
        end else begin
          read_next   = empty_word;
          status_next = ST_NOTFOUND;
        end
      end
      OP_TICK: begin
        status_next = ST_DONE;
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      slot       <= '0;
      count      <= '0;
      found      <= 1'b0;
      fired_slot <= '0;
      empty_word <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        empty_word <= cfg_data;
      end
      // A new result may replace the one taken at this same edge.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= RUN;
            slot  <= '0;
            found <= 1'b0;
          end
        end
        RUN: begin
          if (head.hit) begin
            found <= 1'b1;
            if (job.op == OP_TICK) begin
              fired_slot <= slot;
            end
          end
          if (slot == SlotW'(MaxAlarms - 1)) begin
            state <= FIN;
          end else begin
            slot <= slot + SlotW'(1);
          end
        end
        FIN: begin
          if (load_out) begin
            state <= IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      job.op      <= op_t'(s_axis_tuser);
      job.word    <= s_axis_tdata[22:0];
      job.target  <= s_axis_tdata[30:23];
      job.hour    <= s_axis_tdata[35:31];
      job.minute  <= s_axis_tdata[41:36];
      job.weekday <= s_axis_tdata[44:42];
    end
    if (shift && head.hit) begin
      read_cap <= cell_q[0];
    end
    if (load_out) begin
      out_read_word  <= read_next;
      out_status     <= status_next;
      out_fired      <= (job.op == OP_TICK) && found;
      out_fired_slot <= 4'(fired_slot);
      out_total      <= 5'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_total, out_fired_slot, out_fired, out_status,
                          out_read_word};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxAlarms))
    else $error("entry count exceeds table size");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == RUN) && (slot == '0) && !found)
    else $error("accepted command did not start a chain turn");

  a_turn_length: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) && (slot == SlotW'(MaxAlarms - 1)) |=> (state == FIN))
    else $error("chain turn did not end after the last slot");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_count_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |=> $stable(count))
    else $error("count changed during a chain turn");
`endif

endmodule

[test/alarm_table_weekday_matcher_test.sv]
// Self-checking testbench for the alarm table weekday matcher: directed and random commands.
module alarm_table_weekday_matcher_test;
  import atwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here. The slowest correct run is far shorter: about 1250 commands,
  // each taking at most one random send gap, one turn of the block and one random stall
  // on the output, plus one long output hold.
  localparam int CycleLimit = 400_000;
  localparam int PhaseItems = 200;
  localparam int HoldCycles = 150;

  // One result beat, unpacked into its fields.
  typedef struct packed {
    logic [31:0] read_word;
    status_t     status;
    logic        fired;
    logic [3:0]  fired_slot;
    logic [4:0]  entry_total;
  } alarm_reply_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // Our own copy of the alarm table, its fill level, the last fired slot and the
  // empty word. It advances once for every command beat the block accepts.
  logic [31:0] slot_word [MaxAlarms];
  int          held_count = 0;
  logic [3:0]  last_fire  = '0;
  logic [31:0] empty_fill = '0;

  // Replies the block still owes, oldest first.
  alarm_reply_t replies_due [$];

  // Idling controls. The output side picks up sink_hold once, as one long stall.
  bit send_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int sink_hold = 0;

  int err_count   = 0;
  int cycle_count = 0;
  int n_cmds      = 0;
  int n_fired     = 0;
  int n_full      = 0;
  int n_missing   = 0;
  int n_settings  = 0;

  alarm_table_weekday_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Packs an alarm word from its fields: id, hour, minute, enable, repeat mask.
  function automatic logic [22:0] mk_word(logic [3:0] id, logic [4:0] hour, logic [5:0] minute,
                                          logic en, logic [6:0] rep);
    return {rep, en, minute, hour, id};
  endfunction

  // First held slot whose id matches, or -1.
  function automatic int find_alarm(logic [3:0] id);
    for (int i = 0; i < held_count; i++)
      if (slot_word[i][3:0] == id) return i;
    return -1;
  endfunction

  // Applies one command to the mirrored table and returns the reply the block must give.
  function automatic alarm_reply_t run_alarm_command(op_t op, logic [22:0] word,
                                                     logic [7:0] target, logic [4:0] hour,
                                                     logic [5:0] minute, logic [2:0] wday);
    alarm_reply_t r;
    int          pos;
    logic [31:0] mask;
    logic [31:0] w;
    logic        hit;
    r = '{read_word: '0, status: ST_DONE, fired: 1'b0, fired_slot: '0, entry_total: '0};
    case (op)
      OP_ADD: begin
        if (held_count >= MaxAlarms) begin
          r.status = ST_FULL;
        end else begin
          // Bits above the 23-bit item come from the empty word.
          slot_word[held_count] = {empty_fill[31:23], word};
          held_count++;
        end
      end
      OP_SET_TIM, OP_SET_REP, OP_SET_EN: begin
        pos = find_alarm(word[3:0]);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          mask = (op == OP_SET_TIM) ? TimeMask : (op == OP_SET_REP) ? RepMask : EnMask;
          slot_word[pos] = (slot_word[pos] & ~mask) | ({9'd0, word} & mask);
        end
      end
      OP_DEL_ONE: begin
        // A target above 15 can never equal a 4-bit id.
        pos = (target <= 8'd15) ? find_alarm(target[3:0]) : -1;
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // Later words slide down, but every slot keeps its own id bits.
          for (int i = pos; i + 1 < held_count; i++)
            slot_word[i] = {slot_word[i + 1][31:4], slot_word[i][3:0]};
          slot_word[held_count - 1] = empty_fill;
          held_count--;
        end
      end
      OP_DEL_ALL: begin
        for (int i = 0; i < held_count; i++) slot_word[i] = empty_fill;
        held_count = 0;
      end
      OP_READ: begin
        if (int'(target) >= held_count) begin
          r.read_word = empty_fill;
          r.status    = ST_NOTFOUND;
        end else begin
          r.read_word = slot_word[target[2:0]];
        end
      end
      default: begin
        // Scan in slot order; the first enabled entry at this time that qualifies fires.
        for (int i = 0; i < held_count && !r.fired; i++) begin
          w   = slot_word[i];
          hit = 1'b0;
          if (w[8:4] == hour && w[14:9] == minute && w[EnBit]) begin
            if (w[22:16] == 7'd0) begin
              // A one-shot alarm disarms itself.
              slot_word[i][EnBit] = 1'b0;
              hit = 1'b1;
            end else begin
              // Weekday seven has no bit in the mask.
              hit = (wday != 3'd7) && w[RepLsb + wday];
            end
          end
          if (hit) begin
            last_fire = 4'(i);
            r.fired   = 1'b1;
          end
        end
      end
    endcase
    r.fired_slot  = last_fire;
    r.entry_total = 5'(held_count);
    return r;
  endfunction

  // Offers one command beat, waits for it to be taken and records the reply it owes.
  // tvalid stays high on return so that back-to-back beats need no second assignment.
  task automatic send_cmd(op_t op, logic [22:0] word, logic [7:0] target, logic [4:0] hour,
                          logic [5:0] minute, logic [2:0] wday);
    int           gap;
    alarm_reply_t r;
    gap = send_gaps ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {3'b000, wday, minute, hour, target, word};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = run_alarm_command(op, word, target, hour, minute, wday);
    replies_due.push_back(r);
    n_cmds++;
    if (r.fired) n_fired++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_NOTFOUND) n_missing++;
  endtask

  // Stops offering commands and waits until every owed reply has come back.
  task automatic settle_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() > 0) @(posedge clk);
  endtask

  // Writes the empty word while the block is idle, and mirrors it.
  task automatic write_empty_word(logic [31:0] value);
    settle_idle();
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    empty_fill = value;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Compares one result beat with the oldest owed reply, field by field.
  task automatic check_reply(logic [47:0] beat);
    alarm_reply_t want;
    if (replies_due.size() == 0) begin
      $error("result beat %h arrived with no command outstanding", beat);
      err_count++;
      return;
    end
    want = replies_due.pop_front();
    if (beat[31:0] !== want.read_word) begin
      $error("read_word: expected %h, got %h", want.read_word, beat[31:0]);
      err_count++;
    end
    if (beat[33:32] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, beat[33:32]);
      err_count++;
    end
    if (beat[34] !== want.fired) begin
      $error("fired: expected %0d, got %0d", want.fired, beat[34]);
      err_count++;
    end
    if (beat[38:35] !== want.fired_slot) begin
      $error("fired_slot: expected %0d, got %0d", want.fired_slot, beat[38:35]);
      err_count++;
    end
    if (beat[43:39] !== want.entry_total) begin
      $error("entry_total: expected %0d, got %0d", want.entry_total, beat[43:39]);
      err_count++;
    end
  endtask

  // Result side: takes every result beat, with random stalls or one long hold.
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end else begin
        gap = sink_gaps ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_reply(m_axis_tdata);
    end
  end

  // Random operand helpers. Most times are legal clock times, some use every field bit.
  function automatic logic [4:0] pick_hour();
    return ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] pick_minute();
    return ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
  endfunction

  // Mostly the id of a held alarm, so that edits and deletes find something.
  function automatic logic [3:0] pick_id();
    if (held_count > 0 && $urandom_range(0, 9) < 7)
      return slot_word[$urandom_range(0, held_count - 1)][3:0];
    return 4'($urandom);
  endfunction

  function automatic logic [22:0] random_word(logic [3:0] id);
    logic [6:0] rep;
    rep = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom);
    return mk_word(id, pick_hour(), pick_minute(), $urandom_range(0, 4) != 0, rep);
  endfunction

  // One random command. Ticks usually hit the time of a held alarm so that the
  // scan gets past the time compare and into the enable and weekday logic.
  task automatic random_command();
    int          pick;
    logic [22:0] word;
    logic [7:0]  target;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  wday;
    logic [31:0] w;
    op_t         op;
    pick   = $urandom_range(0, 99);
    word   = random_word(pick_id());
    target = 8'($urandom);
    hour   = pick_hour();
    minute = pick_minute();
    wday   = 3'($urandom_range(0, 7));
    if (pick < 24)      op = OP_ADD;
    else if (pick < 32) op = OP_SET_TIM;
    else if (pick < 40) op = OP_SET_REP;
    else if (pick < 48) op = OP_SET_EN;
    else if (pick < 58) op = OP_DEL_ONE;
    else if (pick < 60) op = OP_DEL_ALL;
    else if (pick < 73) op = OP_READ;
    else                op = OP_TICK;
    if (op == OP_DEL_ONE && $urandom_range(0, 4) != 0) target = {4'd0, pick_id()};
    if (op == OP_READ && $urandom_range(0, 4) != 0) target = 8'($urandom_range(0, 9));
    if (op == OP_TICK && held_count > 0 && $urandom_range(0, 9) < 6) begin
      w      = slot_word[$urandom_range(0, held_count - 1)];
      hour   = w[8:4];
      minute = w[14:9];
    end
    send_cmd(op, word, target, hour, minute, wday);
  endtask

  // Reads, ticks and deletes against the table as it comes out of reset.
  task automatic test_empty_table();
    send_cmd(OP_READ, '0, 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_TICK, '0, 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_DEL_ONE, '0, 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_DEL_ALL, '0, 8'd0, 5'd0, 6'd0, 3'd0);
  endtask

  // Filling, overfilling, matching rules, edits, deletes and reads past the count.
  task automatic test_table_operations();
    write_empty_word(32'hFFFF_FFFF);
    // Slot 0 carries every item bit: id 15, 31:63, enabled, every weekday.
    send_cmd(OP_ADD, 23'h7F_FFFF, 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_ADD, mk_word(4'd1, 5'd7, 6'd30, 1'b1, 7'd0), 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_ADD, mk_word(4'd2, 5'd7, 6'd30, 1'b1, 7'b0000100), 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_ADD, 23'h00_0000, 8'd0, 5'd0, 6'd0, 3'd0);
    for (int id = 4; id < 8; id++)
      send_cmd(OP_ADD, mk_word(4'(id), 5'd23, 6'd59, 1'b0, 7'h55), 8'd0, 5'd0, 6'd0, 3'd0);
    // The table is full now, so this one is refused.
    send_cmd(OP_ADD, mk_word(4'd9, 5'd1, 6'd1, 1'b1, 7'd0), 8'd0, 5'd0, 6'd0, 3'd0);
    // Weekday seven matches no mask bit, so the repeating alarm stays quiet.
    send_cmd(OP_TICK, '0, 8'd0, 5'd31, 6'd63, 3'd7);
    send_cmd(OP_TICK, '0, 8'd0, 5'd31, 6'd63, 3'd6);
    // The one-shot alarm fires and disarms; the next tick at that time finds slot 2.
    send_cmd(OP_TICK, '0, 8'd0, 5'd7, 6'd30, 3'd3);
    send_cmd(OP_TICK, '0, 8'd0, 5'd7, 6'd30, 3'd2);
    send_cmd(OP_TICK, '0, 8'd0, 5'd7, 6'd30, 3'd3);
    send_cmd(OP_SET_TIM, mk_word(4'd1, 5'd12, 6'd0, 1'b0, 7'd0), 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_SET_EN, mk_word(4'd1, 5'd0, 6'd0, 1'b1, 7'd0), 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_SET_REP, mk_word(4'd9, 5'd0, 6'd0, 1'b0, 7'h7F), 8'd0, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_DEL_ONE, '0, 8'd200, 5'd0, 6'd0, 3'd0);
    // Removing id 1 shifts slots 2..7 down while slot 1 keeps id bits 1.
    send_cmd(OP_DEL_ONE, '0, 8'd1, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_READ, '0, 8'd1, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_READ, '0, 8'd7, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_READ, '0, 8'd255, 5'd0, 6'd0, 3'd0);
    send_cmd(OP_DEL_ALL, '0, 8'd0, 5'd0, 6'd0, 3'd0);
  endtask

  // Random commands in phases, each under its own empty word and idling pattern:
  // both sides idling, neither, only the sender, only the receiver.
  task automatic test_random_traffic();
    logic [31:0] fills [6];
    fills[0] = 32'h0000_0000;
    fills[1] = 32'hFFFF_FFFF;
    fills[2] = $urandom;
    fills[3] = 32'h0080_0000;
    fills[4] = $urandom;
    fills[5] = ~fills[2];
    for (int p = 0; p < 6; p++) begin
      write_empty_word(fills[p]);
      send_gaps = (p % 4 == 0) || (p % 4 == 2);
      sink_gaps = (p % 4 == 0) || (p % 4 == 3);
      repeat (PhaseItems) random_command();
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so the
  // result register fills and the block has to stall its command input.
  task automatic test_output_backpressure();
    settle_idle();
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = HoldCycles;
    repeat (24) random_command();
    settle_idle();
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    for (int i = 0; i < MaxAlarms; i++) slot_word[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_table_operations();
    test_random_traffic();
    test_output_backpressure();

    // Drain, then give the block a full turn more to show any stray beat.
    settle_idle();
    repeat (MaxAlarms + 4) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      err_count++;
    end
    $display("Ran %0d commands under %0d empty-word settings, with one long output hold.",
             n_cmds, n_settings);
    $display("Alarms fired %0d times, %0d adds refused as full, %0d ids or slots not found.",
             n_fired, n_full, n_missing);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
